@@ src/dctl_pkg.sv @@
// ----------------------------------------------------------------------------
// dctl_pkg
// Shared types and constants for the joystick / tracker drive controller.
// ----------------------------------------------------------------------------
package dctl_pkg;

   localparam int POS_FRAC_BITS = 4;
   localparam int PULSE_W       = 12;
   localparam int FW_W          = 12;
   localparam int DEN_W         = FW_W + POS_FRAC_BITS;   // frame width in 1/2^F px
   localparam int MUL_A_W       = 18;                      // 2*x - den, signed
   localparam int PROD_W        = MUL_A_W + 11;            // times span (10 b unsigned)
   localparam int NUM_W         = 28;                      // divider numerator magnitude
   localparam int DIV_STEPS     = NUM_W / 2;               // two quotient bits per step
   localparam int CNT_W         = $clog2(DIV_STEPS);
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 15;

   localparam logic [15:0] AXIS_FULL_SCALE = 16'd32767;
   localparam logic [7:0]  DUTY_MAX        = 8'd255;
   localparam logic [13:0] MIN_RADIUS      = 14'(5 << POS_FRAC_BITS);
   localparam logic [11:0] PULSE_MAX       = 12'd4095;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SERVO_CENTER,
      CSR_SERVO_SPAN,
      CSR_AUTO_DUTY,
      CSR_STOP_RADIUS,
      CSR_DEAD_ZONE,
      CSR_FRAME_WIDTH,
      CSR_THROTTLE_AXIS,
      CSR_STEER_AXIS
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SETUP,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_THR,
      KIND_STEER,
      KIND_AUTO
   } kind_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic setup;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

@@ src/dctl_ctrl.sv @@
// ----------------------------------------------------------------------------
// dctl_ctrl
// Sequencer: walks one beat through decode, multiply, divide and commit,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module dctl_ctrl
   import dctl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the previous result beat is gone
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != ST_IDLE);

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit while result beat held");

   a_div_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_done) |=> (state_ff == ST_FIN))
      else $error("divide end not followed by commit state");

   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid without commit");

endmodule

@@ src/dctl_datapath.sv @@
// ----------------------------------------------------------------------------
// dctl_datapath
// Config registers, drive state, one multiplier for both steer kinds and a radix-4
// restoring divider shared by throttle, manual steer and auto steer.
// ----------------------------------------------------------------------------
module dctl_datapath
   import dctl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata,
   input  logic                req_opcode,
   input  logic [7:0]          req_event_type,
   input  logic [7:0]          req_event_number,
   input  logic signed [15:0]  req_event_value,
   input  logic [13:0]         req_target_radius,
   input  logic [15:0]         req_target_x,
   output logic [PULSE_W-1:0]  rsp_servo_pulse,
   output logic [7:0]          rsp_motor_duty,
   output logic                rsp_dir_a,
   output logic                rsp_dir_b,
   output logic                rsp_auto_on,
   output logic                rsp_auto_armed
);

   // configuration
   logic [11:0] center_ff;
   logic [9:0]  span_ff;
   logic [7:0]  auto_duty_ff;
   logic [13:0] stop_radius_ff;
   logic [14:0] dead_zone_ff;
   logic [11:0] frame_width_ff;
   logic [7:0]  thr_axis_ff;
   logic [7:0]  steer_axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff      <= 12'd1850;
         span_ff        <= 10'd500;
         auto_duty_ff   <= 8'd240;
         stop_radius_ff <= 14'd1600;
         dead_zone_ff   <= 15'd4000;
         frame_width_ff <= 12'd320;
         thr_axis_ff    <= 8'd1;
         steer_axis_ff  <= 8'd3;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SERVO_CENTER:  center_ff      <= csr_wdata[11:0];
            CSR_SERVO_SPAN:    span_ff        <= csr_wdata[9:0];
            CSR_AUTO_DUTY:     auto_duty_ff   <= csr_wdata[7:0];
            CSR_STOP_RADIUS:   stop_radius_ff <= csr_wdata[13:0];
            CSR_DEAD_ZONE:     dead_zone_ff   <= csr_wdata[14:0];
            CSR_FRAME_WIDTH:   frame_width_ff <= csr_wdata[11:0];
            CSR_THROTTLE_AXIS: thr_axis_ff    <= csr_wdata[7:0];
            CSR_STEER_AXIS:    steer_axis_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input beat
   logic               op_ff;
   logic [1:0]         type_ff;
   logic [7:0]         num_ff;
   logic signed [15:0] value_ff;
   logic [13:0]        radius_ff;
   logic [15:0]        x_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         type_ff   <= req_event_type[1:0];
         num_ff    <= req_event_number;
         value_ff  <= req_event_value;
         radius_ff <= req_target_radius;
         x_ff      <= req_target_x;
      end
   end

   // drive state, also the result payload
   logic               mode_ff, mode_in;
   logic               armed_ff, armed_in;
   logic               pin_a_ff, pin_a_in;
   logic               pin_b_ff, pin_b_in;
   logic [7:0]         duty_ff, duty_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;

   // ---------------- decode ----------------
   logic                      hit;
   logic                      mode_new;
   logic                      axis_ok;
   logic signed [16:0]        value_ext;
   logic [16:0]               mag;
   logic                      in_dead;
   logic [FW_W-1:0]           w_eff;
   logic [DEN_W-1:0]          den_px;
   logic signed [MUL_A_W-1:0] diff;
   kind_type                  kind_sel;

   kind_type                  kind_ff;
   logic                      hit_ff;
   logic signed [16:0]        v_eff_ff;
   logic [16:0]               mag_eff_ff;
   logic signed [MUL_A_W-1:0] mul_a_ff;
   logic [DEN_W-1:0]          den_px_ff;

   always_comb begin
      hit       = !op_ff && type_ff[0] && (num_ff == 8'd0) && (value_ff == 16'sd1);
      mode_new  = mode_ff ^ hit;
      axis_ok   = !mode_new && type_ff[1];
      value_ext = {value_ff[15], value_ff};
      mag       = value_ext[16] ? 17'(-value_ext) : 17'(value_ext);
      in_dead   = (mag <= {2'b00, dead_zone_ff});
      w_eff     = (frame_width_ff < FW_W'(2)) ? FW_W'(2) : frame_width_ff;
      den_px    = DEN_W'(w_eff) << POS_FRAC_BITS;
      diff      = $signed({1'b0, x_ff, 1'b0}) - $signed(MUL_A_W'(den_px));
      kind_sel  = KIND_NONE;
      if (!op_ff) begin
         if (axis_ok && num_ff == thr_axis_ff)        kind_sel = KIND_THR;
         else if (axis_ok && num_ff == steer_axis_ff) kind_sel = KIND_STEER;
      end else if (mode_ff && armed_ff && radius_ff > MIN_RADIUS) begin
         kind_sel = KIND_AUTO;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         kind_ff    <= kind_sel;
         hit_ff     <= hit;
         v_eff_ff   <= in_dead ? 17'sd0 : value_ext;
         mag_eff_ff <= in_dead ? 17'd0 : mag;
         mul_a_ff   <= (kind_sel == KIND_AUTO) ? diff
                                               : MUL_A_W'(in_dead ? 17'sd0 : value_ext);
         den_px_ff  <= den_px;
      end
   end

   // ---------------- multiply ----------------
   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= PROD_W'(mul_a_ff * $signed({1'b0, span_ff}));
   end

   // ---------------- divider setup ----------------
   logic [26:0]              center_k;
   logic signed [PROD_W-1:0] steer_n;
   logic signed [PROD_W-1:0] sel_n;
   logic [24:0]              thr_n;
   logic [NUM_W-1:0]         n_mag;
   logic                     n_neg;
   logic [DEN_W-1:0]         n_den;

   always_comb begin
      center_k = (27'(center_ff) << 15) - 27'(center_ff);   // center * 32767
      steer_n  = $signed({2'b00, center_k}) - prod_ff;
      thr_n    = (25'(mag_eff_ff) << 8) - 25'(mag_eff_ff);   // |v| * 255
      sel_n    = (kind_ff == KIND_AUTO) ? prod_ff : steer_n;
      n_mag    = '0;
      n_neg    = 1'b0;
      n_den    = DEN_W'(1);
      case (kind_ff)
         KIND_THR: begin
            n_mag = NUM_W'(thr_n);
            n_den = DEN_W'(AXIS_FULL_SCALE);
         end
         KIND_STEER, KIND_AUTO: begin
            n_neg = sel_n[PROD_W-1];
            n_mag = n_neg ? NUM_W'(-sel_n) : NUM_W'(sel_n);
            n_den = (kind_ff == KIND_AUTO) ? den_px_ff : DEN_W'(AXIS_FULL_SCALE);
         end
         default: ;
      endcase
   end

   // ---------------- radix-4 restoring divide ----------------
   logic [NUM_W-1:0] numq_ff, numq_in;   // numerator bits out the top, quotient in below
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] dden_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   r1, r2, r1s, r2s;
   logic             ge1, ge2;

   always_comb begin
      r1      = {rem_ff, numq_ff[NUM_W-1]};
      ge1     = (r1 >= {1'b0, dden_ff});
      r1s     = ge1 ? (r1 - {1'b0, dden_ff}) : r1;
      r2      = {r1s[DEN_W-1:0], numq_ff[NUM_W-2]};
      ge2     = (r2 >= {1'b0, dden_ff});
      r2s     = ge2 ? (r2 - {1'b0, dden_ff}) : r2;
      rem_in  = r2s[DEN_W-1:0];
      numq_in = {numq_ff[NUM_W-3:0], ge1, ge2};
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         numq_ff <= n_mag;
         rem_ff  <= '0;
         dden_ff <= n_den;
         neg_ff  <= n_neg;
         cnt_ff  <= '0;
      end else if (cmd.step) begin
         numq_ff <= numq_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
   end

   assign status.div_done = cmd.step && (cnt_ff == CNT_W'(DIV_STEPS - 1));

   // ---------------- finish: sign, clamp, state update ----------------
   logic signed [NUM_W:0]   sq;
   logic signed [NUM_W+1:0] p;
   logic signed [13:0]      lo, hi;
   logic signed [NUM_W+1:0] lo_w, hi_w;
   logic signed [NUM_W+1:0] p1;
   logic [PULSE_W-1:0]      p2;

   always_comb begin
      sq   = neg_ff ? -$signed({1'b0, numq_ff}) : $signed({1'b0, numq_ff});
      p    = (kind_ff == KIND_AUTO) ? ($signed((NUM_W+2)'(center_ff)) - (NUM_W+2)'(sq))
                                    : (NUM_W+2)'(sq);
      lo   = $signed({2'b00, center_ff}) - $signed({4'b0000, span_ff});
      hi   = $signed({2'b00, center_ff}) + $signed({4'b0000, span_ff});
      lo_w = (NUM_W+2)'(lo);
      hi_w = (NUM_W+2)'(hi);
      if (p < lo_w)      p1 = lo_w;
      else if (p > hi_w) p1 = hi_w;
      else               p1 = p;
      if (p1 < 0)                                 p2 = '0;
      else if (p1 > $signed((NUM_W+2)'(PULSE_MAX))) p2 = PULSE_MAX;
      else                                        p2 = p1[PULSE_W-1:0];
   end

   always_comb begin
      mode_in  = mode_ff;
      armed_in = armed_ff;
      pin_a_in = pin_a_ff;
      pin_b_in = pin_b_ff;
      duty_in  = duty_ff;
      pulse_in = pulse_ff;
      if (cmd.commit) begin
         // button first, then any axis action in the new mode
         if (hit_ff) begin
            mode_in  = !mode_ff;
            armed_in = !mode_ff;
            pulse_in = center_ff;
            duty_in  = '0;
         end
         case (kind_ff)
            KIND_THR: begin
               if (v_eff_ff > 0) begin
                  pin_a_in = 1'b1;
                  pin_b_in = 1'b0;
               end else if (v_eff_ff < 0) begin
                  pin_a_in = 1'b0;
                  pin_b_in = 1'b1;
               end else begin
                  pin_a_in = 1'b0;
                  pin_b_in = 1'b0;
               end
               duty_in = (numq_ff > NUM_W'(DUTY_MAX)) ? DUTY_MAX : numq_ff[7:0];
            end
            KIND_STEER: pulse_in = p2;
            KIND_AUTO: begin
               pulse_in = p2;
               if (radius_ff < stop_radius_ff) begin
                  pin_a_in = 1'b0;
                  pin_b_in = 1'b1;
                  duty_in  = auto_duty_ff;
               end else begin
                  duty_in  = '0;
                  armed_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         armed_ff <= 1'b1;
         pin_a_ff <= 1'b0;
         pin_b_ff <= 1'b0;
         duty_ff  <= '0;
         pulse_ff <= 12'd1850;
      end else begin
         mode_ff  <= mode_in;
         armed_ff <= armed_in;
         pin_a_ff <= pin_a_in;
         pin_b_ff <= pin_b_in;
         duty_ff  <= duty_in;
         pulse_ff <= pulse_in;
      end
   end

   assign rsp_servo_pulse = pulse_ff;
   assign rsp_motor_duty  = duty_ff;
   assign rsp_dir_a       = pin_a_ff;
   assign rsp_dir_b       = pin_b_ff;
   assign rsp_auto_on     = mode_ff;
   assign rsp_auto_armed  = armed_ff;

endmodule

@@ src/joystick_tracker_drive_controller_top.sv @@
// ----------------------------------------------------------------------------
// joystick_tracker_drive_controller_top
// Drive controller: joystick events and tracker frames in, motor and servo
// settings out, one result beat per input beat.
//
//   channel | ports  | handshake        | content
//   --------+--------+------------------+------------------------------------
//   input   | req_*  | valid / stall    | opcode, joystick event, target
//   result  | rsp_*  | valid / stall    | servo pulse, duty, pins, mode flags
//   config  | csr_*  | write enable     | register index, write data
//
// An input beat passes through accept, decode, multiply, divider setup,
// 14 radix-4 divider steps and a commit, in that order.
// Reset is synchronous; config and drive state return to their reset values.
// A new input beat is taken while the previous result still waits; only the
// commit of the next result holds while rsp_stall keeps the old beat.
// ----------------------------------------------------------------------------
module joystick_tracker_drive_controller_top
   import dctl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [7:0]          req_event_type,
   input  logic [7:0]          req_event_number,
   input  logic signed [15:0]  req_event_value,
   input  logic [13:0]         req_target_radius,
   input  logic [15:0]         req_target_x,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PULSE_W-1:0]  rsp_servo_pulse,
   output logic [7:0]          rsp_motor_duty,
   output logic                rsp_dir_a,
   output logic                rsp_dir_b,
   output logic                rsp_auto_on,
   output logic                rsp_auto_armed,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;

   dctl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dctl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_opcode        (req_opcode),
      .req_event_type    (req_event_type),
      .req_event_number  (req_event_number),
      .req_event_value   (req_event_value),
      .req_target_radius (req_target_radius),
      .req_target_x      (req_target_x),
      .rsp_servo_pulse   (rsp_servo_pulse),
      .rsp_motor_duty    (rsp_motor_duty),
      .rsp_dir_a         (rsp_dir_a),
      .rsp_dir_b         (rsp_dir_b),
      .rsp_auto_on       (rsp_auto_on),
      .rsp_auto_armed    (rsp_auto_armed)
   );

endmodule
